FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the hash core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check that is switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hash core check failed");
// Clocked check that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("hash core check failed");
`endif

FILE: sv/s256_pkg.sv
// Types, constants and round functions of the SHA-256 byte stream core.
// No dependencies.
package s256_pkg;

  // One queued input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_final;
  } s256_entry_t;

  // Handshake between the front queue and the engine.
  typedef struct packed {
    logic        valid;
    s256_entry_t entry;
  } s256_queue_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: sv/s256_in_if.sv
// Input channel of the hash core: at most one message byte per transaction.
// No dependencies.
interface s256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_final;
  modport source (output valid, data_byte, has_byte, is_final, input ready);
  modport sink (input valid, data_byte, has_byte, is_final, output ready);
endinterface

FILE: sv/s256_out_if.sv
// Output channel of the hash core: one digest word per transaction.
// No dependencies.
interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: sv/s256_front.sv
// Front end: accepts input transactions and queues those that do any work.
// Depends on s256_pkg.
module s256_front #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  s256_pkg::s256_entry_t  in_entry,
  output s256_pkg::s256_queue_t  queue,
  input  logic                   pop
);
  import s256_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  s256_entry_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          take;

  // An item with neither byte nor final mark changes nothing and is dropped.
  assign in_ready = (count != FULL_CNT);
  assign push     = in_valid && in_ready && (in_entry.has_byte || in_entry.is_final);
  assign take     = pop && (count != '0);

  assign queue.valid = (count != '0);
  assign queue.entry = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

FILE: sv/s256_engine.sv
// Back end: packs bytes, pads, runs the 64 rounds and sends the digest.
// Depends on s256_pkg.
module s256_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  s256_pkg::s256_queue_t queue,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           digest_word,
  output logic [2:0]            word_index,
  output logic                  last_word
);
  import s256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_LOAD, S_ROUND, S_ADD, S_OUT
  } state_t;

  state_t      state;
  state_t      ret_state;
  logic [31:0] blk   [16];
  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [60:0] count;
  logic [5:0]  rnd;
  logic [2:0]  oidx;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [31:0] wt;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] pad_word [16];
  logic [31:0] keep_mask;
  logic [31:0] byte_word;

  assign pos     = count[5:0];
  assign bit_len = {count, 3'b000};
  assign pop     = (state == S_IDLE) && queue.valid;

  assign out_valid   = (state == S_OUT);
  assign digest_word = chain[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  // Shifted byte and the mask of bytes already in the current word.
  always_comb begin
    byte_word = 32'(queue.entry.data_byte) << (5'd24 - {pos[1:0], 3'b000});
    case (pos[1:0])
      2'd0:    keep_mask = 32'h00000000;
      2'd1:    keep_mask = 32'hff000000;
      2'd2:    keep_mask = 32'hffff0000;
      2'd3:    keep_mask = 32'hffffff00;
      default: keep_mask = 32'h00000000;
    endcase
  end

  // Padded block: bytes kept, the pad byte, zeros, and the length if it fits.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (4'(i) < pos[5:2]) begin
        pad_word[i] = blk[i];
      end else if (4'(i) == pos[5:2]) begin
        pad_word[i] = (blk[i] & keep_mask) |
                      (32'(PAD_BYTE) << (5'd24 - {pos[1:0], 3'b000}));
      end else begin
        pad_word[i] = '0;
      end
    end
    if (pos < LEN_POS) begin
      pad_word[14] = bit_len[63:32];
      pad_word[15] = bit_len[31:0];
    end
  end

  // One round: schedule word from the shift line taps, then the two sums.
  always_comb begin
    if (rnd < 6'd16) begin
      wt = blk[0];
    end else begin
      wt = small_sigma1(blk[14]) + blk[9] + small_sigma0(blk[1]) + blk[0];
    end
    t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[rnd] + wt;
    t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Sequencer with the block, round and chaining registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      count     <= '0;
      rnd       <= '0;
      oidx      <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= IV_TABLE[i];
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (queue.valid) begin
            if (queue.entry.has_byte) begin
              blk[pos[5:2]] <= (pos[1:0] == 2'd0) ? byte_word : blk[pos[5:2]] | byte_word;
              count <= count + 1'b1;
              if (pos == 6'd63) begin
                state     <= S_LOAD;
                ret_state <= queue.entry.is_final ? S_PAD : S_IDLE;
              end else if (queue.entry.is_final) begin
                state <= S_PAD;
              end
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < 16; i++) begin
            blk[i] <= pad_word[i];
          end
          state     <= S_LOAD;
          ret_state <= (pos < LEN_POS) ? S_OUT : S_LEN;
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) begin
            blk[i] <= '0;
          end
          blk[14]   <= bit_len[63:32];
          blk[15]   <= bit_len[31:0];
          state     <= S_LOAD;
          ret_state <= S_OUT;
        end
        S_LOAD: begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= chain[i];
          end
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            blk[i] <= blk[i+1];
          end
          blk[15] <= wt;
          rnd     <= rnd + 1'b1;
          if (rnd == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          oidx  <= '0;
          state <= ret_state;
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 1'b1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= IV_TABLE[i];
              end
              count <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: sv/sha256_byte_stream_hash_core.sv
// Throughput: one byte per cycle while the engine waits for bytes; a full 64-byte
// block then holds the engine for its load, 64 rounds and add, and padding and
// the digest output hold it too, while the queue fills and then stalls the input.
// Final item: padding, one or two compressions, then eight output words.
// Reset (rst, synchronous, active high) empties the queue and restores the IV.
// Top level of the SHA-256 core; depends on s256_pkg, the two interfaces,
// s256_front and s256_engine.
module sha256_byte_stream_hash_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst,
  s256_in_if.sink    in_item,
  s256_out_if.source result
);
  import s256_pkg::*;

  s256_entry_t in_entry;
  s256_queue_t queue;
  logic        pop;

  assign in_entry.data_byte = in_item.data_byte;
  assign in_entry.has_byte  = in_item.has_byte;
  assign in_entry.is_final  = in_item.is_final;

  s256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .in_entry (in_entry),
    .queue    (queue),
    .pop      (pop)
  );

  s256_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .queue       (queue),
    .pop         (pop),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .digest_word (result.digest_word),
    .word_index  (result.word_index),
    .last_word   (result.last_word)
  );
endmodule

FILE: sv/s256_checker.sv
// Port-level checks of the hash core output, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module s256_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);
  // Coming out of a reset cycle, no word is offered.
  `CHK_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid)
  // A stalled word keeps its value.
  `CHK_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(digest_word))
  // The last mark goes with the eighth word only.
  `CHK_ASSERT(a_last, clk, rst, !out_valid || (last_word == (word_index == 3'd7)))
  // The eight words follow one another without a gap and in order.
  `CHK_ASSERT(a_next, clk, rst,
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
  // After the last word the digest is over.
  `CHK_ASSERT(a_done, clk, rst, out_valid && out_ready && last_word |=> !out_valid)
endmodule

bind sha256_byte_stream_hash_core s256_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .digest_word (result.digest_word),
  .word_index  (result.word_index),
  .last_word   (result.last_word)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the SHA-256 byte stream hash core.
// Depends on s256_pkg, s256_in_if, s256_out_if and sha256_byte_stream_hash_core.
module testbench;
  import s256_pkg::*;

  localparam int ITEM_TARGET = 230;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  typedef struct {
    logic [7:0]  data;
    logic        has;
    logic        fin;
    logic        known;
    logic [31:0] first_word;
  } stim_row_t;

  logic clk;
  logic rst;
  s256_in_if  in_item ();
  s256_out_if result ();

  sha256_byte_stream_hash_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_item(in_item),
    .result (result)
  );

  // Shadow copy of the hashing state.
  logic [31:0] msg_block [16];
  logic [31:0] hash_state [8];
  logic [60:0] byte_count;
  digest_word_t pending_words [$];

  int  mismatches = 0;
  int  words_seen = 0;
  int  digests_done = 0;
  int  items_sent = 0;
  int  cycles = 0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;

  // Directed stimulus: empty message, idle item, "abc", single extreme bytes,
  // and a message closed by a final mark without a byte.
  stim_row_t directed [] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0}
  };

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Writes one byte of the block, big-endian within each word.
  task automatic place_byte(input int pos, input logic [7:0] b);
    int w;
    int sh;
    w  = pos / 4;
    sh = 24 - 8 * (pos % 4);
    if (pos % 4 == 0) begin
      msg_block[w] = 32'(b) << sh;
    end else begin
      msg_block[w] = msg_block[w] | (32'(b) << sh);
    end
  endtask

  // Sixty-four rounds over the current block into the hash state.
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, x15, x2, t1, t2, ev, av;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x15 = w[(t - 15) & 15];
        x2  = w[(t - 2) & 15];
        wt = w[t & 15] + (rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3))
           + w[(t - 7) & 15] + (rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10));
        w[t & 15] = wt;
      end
      ev = v[4];
      av = v[0];
      t1 = v[7] + (rot_right(ev, 6) ^ rot_right(ev, 11) ^ rot_right(ev, 25))
         + ((ev & v[5]) ^ (~ev & v[6])) + K_TABLE[t] + wt;
      t2 = (rot_right(av, 2) ^ rot_right(av, 13) ^ rot_right(av, 22))
         + ((av & v[1]) ^ (av & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  // Updates the shadow state for one accepted transaction and queues the
  // digest words that a final mark releases.
  task automatic hash_absorb(input logic [7:0] d, input logic h, input logic f);
    int pos;
    logic [63:0] bits;
    digest_word_t dw;
    if (h) begin
      pos = int'(byte_count[5:0]);
      place_byte(pos, d);
      byte_count = byte_count + 61'd1;
      if (pos == 63) compress_block();
    end
    if (f) begin
      pos  = int'(byte_count[5:0]);
      bits = {byte_count, 3'b000};
      place_byte(pos, PAD_BYTE);
      for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
      if (pos >= int'(LEN_POS)) begin
        compress_block();
        for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
      end
      msg_block[14] = bits[63:32];
      msg_block[15] = bits[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        pending_words = {pending_words, dw};
        hash_state[i] = IV_TABLE[i];
      end
      byte_count = '0;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (mismatches < 10) begin
      $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
    end
    mismatches++;
  endtask

  // Presents one transaction, with random idle cycles ahead of it.
  task automatic send_item(input logic [7:0] d, input logic h, input logic f);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_item.valid = 1'b0;
      @(negedge clk);
    end
    in_item.valid     = 1'b1;
    in_item.data_byte = d;
    in_item.has_byte  = h;
    in_item.is_final  = f;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    items_sent++;
  endtask

  // Sends one message of the given length with random content.
  task automatic send_message(input int len);
    logic fin_on_byte;
    fin_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, fin_on_byte && (i == len - 1));
    end
    if (!fin_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input monitor: every accepted transaction goes through the predictor.
  always @(posedge clk) begin
    in_fire <= !rst && in_item.valid && in_item.ready;
    if (!rst && in_item.valid && in_item.ready) begin
      hash_absorb(in_item.data_byte, in_item.has_byte, in_item.is_final);
    end
  end

  // Output monitor: each digest word against the oldest expectation.
  always @(posedge clk) begin
    digest_word_t dw;
    if (!rst && result.valid && result.ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected digest word", 32'h0, result.digest_word);
      end else begin
        dw = pending_words.pop_front();
        if (result.digest_word !== dw.word)
          note_mismatch("digest_word", dw.word, result.digest_word);
        if (result.word_index !== dw.idx)
          note_mismatch("word_index", 32'(dw.idx), 32'(result.word_index));
        if (result.last_word !== dw.last)
          note_mismatch("last_word", 32'(dw.last), 32'(result.last_word));
        if (dw.last) digests_done++;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    result.ready <= !rst && (calm || $urandom_range(0, 99) >= 31);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;
    rst = 1'b1;
    in_item.valid = 1'b0;
    in_item.data_byte = 8'h00;
    in_item.has_byte = 1'b0;
    in_item.is_final = 1'b0;
    result.ready = 1'b0;
    for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
    for (int i = 0; i < 8; i++) hash_state[i] = IV_TABLE[i];
    byte_count = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed rows; known digests are checked against the prediction too.
    foreach (directed[r]) begin
      send_item(directed[r].data, directed[r].has, directed[r].fin);
      if (directed[r].known) begin
        if (pending_words[pending_words.size() - 8].word !== directed[r].first_word)
          note_mismatch("known digest", directed[r].first_word,
                        pending_words[pending_words.size() - 8].word);
      end
    end

    // Random messages, mostly short, some across the padding boundaries.
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent > 110) && (items_sent < 170);
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(0, 12);
      else if (pick < 90) len = 54 + $urandom_range(0, 11);
      else len = $urandom_range(100, 130);
      // The last message is shortened so the run stays near its item budget.
      if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
      send_message(len);
    end
    calm = 1'b0;
    in_item.valid = 1'b0;

    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d transactions sent, %0d digests (%0d words) checked",
             items_sent, digests_done, words_seen);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
